// ===== rtl/rpl_pkg.sv =====
package rpl_pkg;

	localparam int ID_W  = 16;
	localparam int OUT_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_POST = 3'b100
	} top_state_t;

	typedef enum logic [3:0] {
		H_IDLE = 4'b0001,
		H_SQA  = 4'b0010,
		H_SQB  = 4'b0100,
		H_ROOT = 4'b1000
	} hyp_state_t;

endpackage

// ===== rtl/rpl_hyp.sv =====
module rpl_hyp #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] a,
	input  logic [COORD_BITS-1:0] b,
	output logic                  done,
	output logic [COORD_BITS:0]   root
);

	localparam int RADW = 2 * COORD_BITS + 2;
	localparam int RW   = COORD_BITS + 4;
	localparam int CW   = $clog2(COORD_BITS + 1);

	rpl_pkg::hyp_state_t state_q;

	logic [COORD_BITS-1:0]   a_q, b_q;
	logic [COORD_BITS-1:0]   mul_op;
	logic [2*COORD_BITS-1:0] prod;
	logic [RADW-1:0]         rad_q;
	logic [RW-1:0]           rem_q, rem_sh, trial;
	logic [COORD_BITS:0]     root_q;
	logic [CW-1:0]           cnt_q;
	logic                    done_q;
	logic                    fits;

	// shared multiplier: squares a, then b
	assign mul_op = (state_q == rpl_pkg::H_SQA) ? a_q : b_q;
	assign prod   = mul_op * mul_op;

	// one result bit per cycle, two radicand bits brought down
	assign rem_sh = {rem_q[RW-3:0], rad_q[RADW-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpl_pkg::H_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				rpl_pkg::H_IDLE: begin
					if (start) state_q <= rpl_pkg::H_SQA;
				end
				rpl_pkg::H_SQA: state_q <= rpl_pkg::H_SQB;
				rpl_pkg::H_SQB: begin
					cnt_q   <= '0;
					state_q <= rpl_pkg::H_ROOT;
				end
				rpl_pkg::H_ROOT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(COORD_BITS)) begin
						done_q  <= 1'b1;
						state_q <= rpl_pkg::H_IDLE;
					end
				end
				default: state_q <= rpl_pkg::H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rpl_pkg::H_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			rpl_pkg::H_SQA: rad_q <= RADW'(prod);
			rpl_pkg::H_SQB: begin
				rad_q  <= rad_q + RADW'(prod);
				rem_q  <= '0;
				root_q <= '0;
			end
			rpl_pkg::H_ROOT: begin
				rad_q  <= {rad_q[RADW-3:0], 2'b00};
				rem_q  <= fits ? rem_sh - trial : rem_sh;
				root_q <= {root_q[COORD_BITS-1:0], fits};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/route_path_length_top.sv =====
// channel  dir  handshake          tdata (low bit up)              tuser      tlast
// s_*      in   s_tvalid/s_tready  point_id, pos_x, pos_y          route_end  set_end
// m_*      out  m_tvalid/m_tready  total_length                    -          -
//
// A point that adds a distance goes through two squares on one multiplier, then one
// root bit per cycle in the shift-subtract unit; any other word skips that unit.
// s_tready is low while a word is in work. A set-end word waits until the output
// register is free. Reset clears total, previous point and output valid.
module route_path_length_top #(
	parameter int COORD_BITS = 16,
	parameter int SUM_BITS   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// point_id, pos_x, pos_y, zero fill
	input  logic [((rpl_pkg::ID_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// route_end
	input  logic                    s_tuser,
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// total_length
	output logic [rpl_pkg::OUT_W-1:0] m_tdata
);

	localparam int DW = COORD_BITS + 1;
	localparam int AW = ((SUM_BITS > DW) ? SUM_BITS : DW) + 1;
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
	localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS - 1){1'b0}}};

	rpl_pkg::top_state_t state_q;

	logic [rpl_pkg::ID_W-1:0] in_id;
	logic [COORD_BITS-1:0]    in_x, in_y, bx, by, bpx, bpy, dx, dy;
	logic                     accept, need_dist, out_free, emit;
	logic                     hyp_done;
	logic [DW-1:0]            hyp_root;
	logic [AW-1:0]            sum_next;

	logic [COORD_BITS-1:0]    prev_x_q, prev_y_q, x_q, y_q;
	logic                     have_prev_q, id_nz_q, rend_q, send_q, m_tvalid_q;
	logic [SUM_BITS-1:0]      sum_q;
	logic [rpl_pkg::OUT_W-1:0] m_tdata_q;

	assign in_id = s_tdata[rpl_pkg::ID_W-1:0];
	assign in_x  = s_tdata[rpl_pkg::ID_W +: COORD_BITS];
	assign in_y  = s_tdata[rpl_pkg::ID_W + COORD_BITS +: COORD_BITS];

	// offset binary keeps signed order
	assign bx  = in_x ^ SIGN_BIT;
	assign by  = in_y ^ SIGN_BIT;
	assign bpx = prev_x_q ^ SIGN_BIT;
	assign bpy = prev_y_q ^ SIGN_BIT;
	assign dx  = (bx > bpx) ? bx - bpx : bpx - bx;
	assign dy  = (by > bpy) ? by - bpy : bpy - by;

	assign s_tready  = (state_q == rpl_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign need_dist = (in_id != '0) && have_prev_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit      = (state_q == rpl_pkg::ST_POST) && send_q && out_free;
	assign sum_next  = AW'(sum_q) + AW'(hyp_root);

	rpl_hyp #(
		.COORD_BITS(COORD_BITS)
	) u_hyp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && need_dist),
		.a     (dx),
		.b     (dy),
		.done  (hyp_done),
		.root  (hyp_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpl_pkg::ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (emit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				rpl_pkg::ST_IDLE: begin
					if (accept) state_q <= need_dist ? rpl_pkg::ST_CALC : rpl_pkg::ST_POST;
				end
				rpl_pkg::ST_CALC: begin
					if (hyp_done) begin
						// saturate the running total
						if (sum_next > AW'(SUM_MAX)) sum_q <= SUM_MAX;
						else sum_q <= sum_next[SUM_BITS-1:0];
						state_q <= rpl_pkg::ST_POST;
					end
				end
				rpl_pkg::ST_POST: begin
					if (!send_q || out_free) begin
						if (id_nz_q) begin
							prev_x_q <= x_q;
							prev_y_q <= y_q;
						end
						have_prev_q <= (id_nz_q || have_prev_q) && !rend_q && !send_q;
						if (send_q) sum_q <= '0;
						state_q <= rpl_pkg::ST_IDLE;
					end
				end
				default: state_q <= rpl_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_nz_q <= (in_id != '0);
			x_q     <= in_x;
			y_q     <= in_y;
			rend_q  <= s_tuser;
			send_q  <= s_tlast;
		end
		if (emit) m_tdata_q <= rpl_pkg::OUT_W'(sum_q);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/rpl_check.sv =====
module rpl_check #(
	parameter int COORD_BITS = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [((rpl_pkg::ID_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input logic                    s_tuser,
	input logic                    s_tlast,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [rpl_pkg::OUT_W-1:0] m_tdata
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// hold a waiting input word
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable({s_tlast, s_tuser, s_tdata}))
		else $error("input word changed while waiting");

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	// busy after every accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input taken while a word is in work");

	// only a set-end word raises a result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !s_tlast |=> !$rose(m_tvalid))
		else $error("result raised without set end");

endmodule

bind route_path_length_top rpl_check #(
	.COORD_BITS(COORD_BITS)
) u_rpl_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== verif/tb.sv =====
module tb;

	localparam int COORD_BITS = 16;
	localparam int SUM_BITS   = 32;
	localparam int DW         = ((rpl_pkg::ID_W + 2 * COORD_BITS + 7) / 8) * 8;
	localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF;
	localparam int SETTLE     = 4 * (COORD_BITS + 5);
	localparam int DUE_DEPTH  = 1024;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DW-1:0]       s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b1;
	logic [rpl_pkg::OUT_W-1:0] m_tdata;

	logic [rpl_pkg::OUT_W-1:0] due_mem [0:DUE_DEPTH-1];
	int                  due_wr = 0;
	int                  due_rd = 0;
	logic [rpl_pkg::OUT_W-1:0] want_total;
	logic signed [15:0]  last_x;
	logic signed [15:0]  last_y;
	logic                route_open;
	longint unsigned     run_total;
	int                  mismatches;
	bit                  calm;
	bit                  allow_gaps;

	route_path_length_top #(
		.COORD_BITS(COORD_BITS),
		.SUM_BITS  (SUM_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic void fold_point(input logic [15:0] id, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic rend, input logic send);
		int dx;
		int dy;
		longint unsigned sq;
		longint unsigned root;
		longint unsigned trial;
		if (id != 0) begin
			if (route_open) begin
				dx = int'(x) - int'(last_x);
				dy = int'(y) - int'(last_y);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
				root = 0;
				for (int b = 17; b >= 0; b--) begin
					trial = root | (64'd1 << b);
					if (trial * trial <= sq) root = trial;
				end
				if (root > TOTAL_MAX - run_total) run_total = TOTAL_MAX;
				else run_total += root;
			end
			last_x = x;
			last_y = y;
			route_open = 1'b1;
		end
		if (rend) route_open = 1'b0;
		if (send) begin
			due_mem[due_wr % DUE_DEPTH] = run_total[rpl_pkg::OUT_W-1:0];
			due_wr++;
			run_total = 0;
			route_open = 1'b0;
		end
	endfunction

	task automatic send_point(input logic [15:0] id, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic rend, input logic send);
		if (allow_gaps && !calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x, id};
		s_tuser  <= rend;
		s_tlast  <= send;
		do @(posedge clk); while (!s_tready);
		fold_point(id, x, y, rend, send);
	endtask

	task automatic test_directed();
		send_point(16'd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
		send_point(16'd1, 16'sd0, 16'sd0, 1'b0, 1'b1);
		send_point(16'hFFFF, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
		send_point(16'd2, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
		send_point(16'd3, 16'sd0, 16'sd0, 1'b0, 1'b1);
		send_point(16'd5, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_point(16'd0, 16'sd1000, 16'sd1000, 1'b0, 1'b0);
		send_point(16'd6, 16'sh0300, 16'sh0400, 1'b0, 1'b0);
		send_point(16'd0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
		send_point(16'd7, 16'sd100, 16'sd100, 1'b0, 1'b0);
		send_point(16'd8, 16'sd100, 16'sd356, 1'b0, 1'b1);
		send_point(16'd9, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_point(16'd10, 16'sd3, 16'sd4, 1'b0, 1'b1);
		send_point(16'd11, 16'sd50, 16'sd50, 1'b0, 1'b1);
		send_point(16'd12, -16'sd1, -16'sd1, 1'b0, 1'b0);
		send_point(16'd0, 16'sh5555, 16'shAAAA, 1'b1, 1'b1);
		send_point(16'h8000, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
		send_point(16'h7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
	endtask

	task automatic test_long_hops();
		int n;
		allow_gaps = 1'b0;
		n = 40;
		for (int i = 0; i < n; i++) begin
			if (i % 2 == 0) send_point(16'(i + 1), 16'sh8000, 16'sh8000, 1'b0, i == n - 1);
			else send_point(16'(i + 1), 16'sh7FFF, 16'sh7FFF, 1'b0, i == n - 1);
		end
		allow_gaps = 1'b1;
	endtask

	task automatic test_route_sets(input int n_items);
		int sent;
		int routes;
		int pts;
		int mode;
		logic [15:0] id;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic rend;
		logic send;
		sent = 0;
		x = 0;
		y = 0;
		while (sent < n_items) begin
			routes = $urandom_range(1, 4);
			for (int r = 0; r < routes; r++) begin
				pts = $urandom_range(1, 6);
				mode = $urandom_range(0, 3);
				for (int p = 0; p < pts; p++) begin
					case (mode)
						0: begin
							x = 16'($urandom);
							y = 16'($urandom);
						end
						1: begin
							x = x + 16'($urandom_range(0, 511)) - 16'd256;
							y = y + 16'($urandom_range(0, 511)) - 16'd256;
						end
						2: begin
							x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
							y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
						end
						default: begin
							x = 16'($urandom_range(0, 15)) - 16'd8;
							y = 16'($urandom_range(0, 15)) - 16'd8;
						end
					endcase
					id   = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
					rend = (p == pts - 1) && ($urandom_range(0, 9) != 0);
					send = (r == routes - 1) && (p == pts - 1);
					if ($urandom_range(0, 9) == 0) begin
						id   = 16'($urandom);
						x    = 16'($urandom);
						y    = 16'($urandom);
						rend = 1'($urandom_range(0, 1));
						send = ($urandom_range(0, 7) == 0);
					end
					send_point(id, x, y, rend, send);
					sent++;
				end
			end
		end
	endtask

	task automatic test_calm_sets();
		calm = 1'b1;
		test_route_sets(100);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_wr == due_rd) begin
				$display("%0t total_length: expected none, actual %0d", $time, m_tdata);
				mismatches++;
			end else begin
				want_total = due_mem[due_rd % DUE_DEPTH];
				due_rd++;
				if (m_tdata !== want_total) begin
					$display("%0t total_length: expected %0d, actual %0d",
						$time, want_total, m_tdata);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int guard;
		route_open = 1'b0;
		last_x = 0;
		last_y = 0;
		run_total = 0;
		mismatches = 0;
		calm = 1'b0;
		allow_gaps = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_hops();
		test_route_sets(500);
		test_calm_sets();
		s_tvalid <= 1'b0;
		guard = 0;
		while (due_wr != due_rd && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		if (due_wr != due_rd) begin
			$display("%0t total_length: expected %0d, actual none (%0d missing)",
				$time, due_mem[due_rd % DUE_DEPTH], due_wr - due_rd);
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
